[rtl/ftbr_pkg.sv]
`default_nettype none

package ftbr_pkg;

    localparam int NUM_BLOCKS_DEF  = 25;
    localparam int BLOCK_BYTES_DEF = 512;

    localparam int OFF_W   = 24;
    localparam int SLOT_W  = 6;
    localparam int TRACK_W = 8;
    localparam int TAG_W   = 10;
    localparam int PTAG_W  = 9;

    localparam logic [TRACK_W-1:0] MAX_TRACK_RESET = 8'd79;
    localparam logic [TRACK_W-1:0] TRACK_RESET_TAG = 8'hff;
    localparam logic [1:0]         SIDE_RESET_TAG  = 2'd3;
    localparam logic [TAG_W-1:0]   TAG_RESET       = {TRACK_RESET_TAG, SIDE_RESET_TAG};

    localparam logic [2:0] MODE_START = 3'd0;
    localparam logic [2:0] MODE_STEP  = 3'd1;
    localparam logic [2:0] MODE_SCAN  = 3'd2;
    localparam logic [2:0] MODE_FETCH = 3'd3;
    localparam logic [2:0] MODE_STOP  = 3'd4;

    typedef struct packed {
        logic accept;
        logic start;
        logic step;
        logic stop;
        logic fail;
        logic busy;
        logic sweep_init;
        logic rd_scan;
        logic calc;
        logic mul;
        logic seek;
        logic sweep_rd;
        logic sweep_end;
        logic load_out;
    } ftbr_cmd_t;

    typedef struct packed {
        logic running;
        logic pending;
        logic out_full;
        logic scan_miss;
        logic sweep_last;
    } ftbr_stat_t;

endpackage

`default_nettype wire

[rtl/ftbr_ctrl.sv]
`default_nettype none

module ftbr_ctrl
    import ftbr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] mode,
    input  wire logic       fetch_ok,
    input  wire logic       out_ready,
    input  wire ftbr_stat_t stat,
    output ftbr_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_MUL,
        S_SEEK,
        S_SWEEP,
        S_DRAIN,
        S_SWEND
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_next;
    logic   done_reg;

    logic fire;
    assign in_ready = (state_reg == S_IDLE) && !done_reg;
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        done_next  = done_reg;
        if (done_reg)
        begin
            if (!stat.out_full || out_ready)
            begin
                cmd.load_out = 1'b1;
                done_next    = 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (fire)
                    begin
                        cmd.accept = 1'b1;
                        done_next  = 1'b1;
                        case (mode)
                            MODE_START: cmd.start = 1'b1;
                            MODE_STEP:  cmd.step  = 1'b1;
                            MODE_STOP:  cmd.stop  = 1'b1;
                            MODE_SCAN:
                            begin
                                if (stat.running && stat.pending)
                                begin
                                    cmd.busy = 1'b1;
                                end
                                else if (stat.running)
                                begin
                                    done_next  = 1'b0;
                                    state_next = S_READ;
                                end
                            end
                            MODE_FETCH:
                            begin
                                if (stat.running && stat.pending)
                                begin
                                    if (!fetch_ok)
                                    begin
                                        cmd.fail = 1'b1;
                                    end
                                    else
                                    begin
                                        cmd.sweep_init = 1'b1;
                                        done_next      = 1'b0;
                                        state_next     = S_SWEEP;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ:
                begin
                    cmd.rd_scan = 1'b1;
                    state_next  = S_CALC;
                end
                S_CALC:
                begin
                    cmd.calc = 1'b1;
                    if (stat.scan_miss)
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                S_MUL:
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_SEEK;
                end
                S_SEEK:
                begin
                    cmd.seek   = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                S_SWEEP:
                begin
                    cmd.sweep_rd = 1'b1;
                    if (stat.sweep_last)
                    begin
                        state_next = S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_next = S_SWEND;
                end
                S_SWEND:
                begin
                    cmd.sweep_end = 1'b1;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

`default_nettype wire

[rtl/ftbr_datapath.sv]
`default_nettype none

module ftbr_datapath
    import ftbr_pkg::*;
#(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ftbr_cmd_t          cmd,
    output ftbr_stat_t              stat,
    input  wire logic               cfg_valid,
    input  wire logic [TRACK_W-1:0] cfg_data,
    input  wire logic               step_dir,
    input  wire logic               side_pin,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic [TRACK_W-1:0]      head_pos,
    output logic                    track_zero_n,
    output logic                    fetch_req,
    output logic [SLOT_W-1:0]       fetch_slot,
    output logic [OFF_W-1:0]        fetch_offset,
    output logic                    seek_needed,
    output logic                    stream_on,
    output logic                    busy_res,
    output logic                    failed
);

    localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int BASE_W = $clog2(512 * NUM_BLOCKS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

    logic [TAG_W-1:0]      tag_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] tag_valid_reg;

    logic [TRACK_W-1:0] head_limit_reg;
    logic [TRACK_W-1:0] head_reg;
    logic [IDX_W-1:0]   scan_slot_reg;
    logic [OFF_W-1:0]   next_off_reg;
    logic               streaming_reg;
    logic               pending_reg;
    logic [PTAG_W-1:0]  ptag_reg;
    logic               running_reg;
    logic               fault_reg;
    logic               side_reg;

    logic [TAG_W-1:0]   rd_data_reg;
    logic               rd_vld_reg;
    logic               cmp_vld_reg;
    logic [IDX_W-1:0]   cnt_reg;
    logic               miss_reg;

    logic               req_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic [BASE_W-1:0]  base_reg;
    logic [OFF_W-1:0]   off_reg;
    logic               seek_reg;
    logic               busy_reg;

    logic               out_valid_reg;

    logic [IDX_W-1:0]   rd_addr;
    logic [TAG_W-1:0]   eff_tag;
    logic [TAG_W-1:0]   scan_want;
    logic [TAG_W-1:0]   sweep_want;
    logic               side_bit;
    logic [BASE_W-1:0]  base_next;
    logic [OFF_W-1:0]   off_next;

    assign side_bit   = ~side_reg;
    assign rd_addr    = cmd.rd_scan ? scan_slot_reg : cnt_reg;
    assign eff_tag    = rd_vld_reg ? rd_data_reg : TAG_RESET;
    assign scan_want  = {head_reg, 1'b0, side_bit};
    assign sweep_want = {ptag_reg[PTAG_W-1:1], 1'b0, ptag_reg[0]};
    assign base_next  = BASE_W'({head_reg, side_bit}) * BASE_W'(NUM_BLOCKS)
                      + BASE_W'(scan_slot_reg);
    assign off_next   = OFF_W'(base_reg) * OFF_W'(BLOCK_BYTES);

    assign stat.running    = running_reg;
    assign stat.pending    = pending_reg;
    assign stat.out_full   = out_valid_reg;
    assign stat.scan_miss  = eff_tag != scan_want;
    assign stat.sweep_last = cnt_reg == LAST_IDX;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_scan || cmd.sweep_rd)
        begin
            rd_data_reg <= tag_mem[rd_addr];
        end
        if (cmd.calc && stat.scan_miss)
        begin
            tag_mem[scan_slot_reg] <= scan_want;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_valid_reg  <= '0;
            head_limit_reg <= MAX_TRACK_RESET;
            head_reg       <= '0;
            scan_slot_reg  <= '0;
            next_off_reg   <= '0;
            streaming_reg  <= 1'b0;
            pending_reg    <= 1'b0;
            ptag_reg       <= '0;
            running_reg    <= 1'b0;
            fault_reg      <= 1'b0;
            side_reg       <= 1'b0;
            rd_vld_reg     <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            cnt_reg        <= '0;
            miss_reg       <= 1'b0;
            req_reg        <= 1'b0;
            slot_reg       <= '0;
            base_reg       <= '0;
            off_reg        <= '0;
            seek_reg       <= 1'b0;
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            head_pos       <= '0;
            track_zero_n   <= 1'b0;
            fetch_req      <= 1'b0;
            fetch_slot     <= '0;
            fetch_offset   <= '0;
            seek_needed    <= 1'b0;
            stream_on      <= 1'b0;
            busy_res       <= 1'b0;
            failed         <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                head_limit_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                side_reg <= side_pin;
                req_reg  <= 1'b0;
                slot_reg <= '0;
                off_reg  <= '0;
                seek_reg <= 1'b0;
                busy_reg <= cmd.busy;
            end
            if (cmd.start)
            begin
                head_reg      <= '0;
                tag_valid_reg <= '0;
                scan_slot_reg <= '0;
                next_off_reg  <= '0;
                streaming_reg <= 1'b0;
                pending_reg   <= 1'b0;
                ptag_reg      <= '0;
                running_reg   <= 1'b1;
                fault_reg     <= 1'b0;
            end
            if (cmd.step)
            begin
                if (!step_dir && (head_reg < head_limit_reg))
                begin
                    head_reg <= head_reg + 1'b1;
                end
                else if (step_dir && (head_reg != '0))
                begin
                    head_reg <= head_reg - 1'b1;
                end
            end
            if (cmd.stop)
            begin
                running_reg   <= 1'b0;
                streaming_reg <= 1'b0;
                pending_reg   <= 1'b0;
            end
            if (cmd.fail)
            begin
                fault_reg     <= 1'b1;
                running_reg   <= 1'b0;
                streaming_reg <= 1'b0;
                pending_reg   <= 1'b0;
            end
            if (cmd.rd_scan || cmd.sweep_rd)
            begin
                rd_vld_reg <= tag_valid_reg[rd_addr];
            end
            if (cmd.calc)
            begin
                scan_slot_reg <= (scan_slot_reg == LAST_IDX) ? '0 : scan_slot_reg + 1'b1;
                if (stat.scan_miss)
                begin
                    tag_valid_reg[scan_slot_reg] <= 1'b1;
                    req_reg       <= 1'b1;
                    slot_reg      <= scan_slot_reg;
                    base_reg      <= base_next;
                    streaming_reg <= 1'b0;
                    pending_reg   <= 1'b1;
                    ptag_reg      <= {head_reg, side_bit};
                end
            end
            if (cmd.mul)
            begin
                off_reg <= off_next;
            end
            if (cmd.seek)
            begin
                seek_reg     <= off_reg != next_off_reg;
                next_off_reg <= off_reg + OFF_W'(BLOCK_BYTES);
            end
            if (cmd.sweep_init)
            begin
                pending_reg <= 1'b0;
                cnt_reg     <= '0;
                miss_reg    <= 1'b0;
            end
            if (cmd.sweep_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            cmp_vld_reg <= cmd.sweep_rd;
            if (cmp_vld_reg && (eff_tag != sweep_want))
            begin
                miss_reg <= 1'b1;
            end
            if (cmd.sweep_end)
            begin
                streaming_reg <= !miss_reg;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
                head_pos      <= head_reg;
                track_zero_n  <= head_reg != '0;
                fetch_req     <= req_reg;
                fetch_slot    <= SLOT_W'(slot_reg);
                fetch_offset  <= off_reg;
                seek_needed   <= seek_reg;
                stream_on     <= streaming_reg;
                busy_res      <= busy_reg;
                failed        <= fault_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

    a_pending_running: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> running_reg)
        else $error("fetch outstanding while not running");

    a_stream_idle: assert property (@(posedge clk) disable iff (!rst_n)
        streaming_reg |-> !pending_reg)
        else $error("streaming with a fetch outstanding");

    a_fault_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        fault_reg |-> !running_reg)
        else $error("running after a failed fetch");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(scan_slot_reg) < NUM_BLOCKS)
        else $error("scan slot out of range");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transfer");

endmodule

`default_nettype wire

[rtl/floppy_track_buffer_refill.sv]
// Floppy drive emulator core: head position tracking and track buffer refill.
// Input channel (in_valid/in_ready) carries one command per transfer: start,
// step, scan, fetch done or stop, with step_dir, side_pin and fetch_ok.
// Output channel (out_valid/out_ready) returns one result per command: head
// position, track-zero line, fetch request with slot, byte offset and seek
// flag, streaming, busy and failure flags.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) sets the highest track;
// write it only while the block is idle. cfg_ready is always high.
// Start, step, stop and ignored commands go straight to their result; a scan
// reads the tag memory and compares, and on a refill goes on through the
// offset multiply and the seek compare; an accepted fetch done makes one tag
// memory read per slot. The next command is taken the cycle after its result
// is loaded. One command is in flight at a time.
// A stalled receiver holds the result in the output register; the next
// command is taken meanwhile and waits at its end for the register to free.
// Reset empties the output register, sets the highest track to 79, the head
// to track 0 and every slot tag to its unused value, with the block stopped.
`default_nettype none

module floppy_track_buffer_refill
    import ftbr_pkg::*;
#(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [TRACK_W-1:0] cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         mode,
    input  wire logic               step_dir,
    input  wire logic               side_pin,
    input  wire logic               fetch_ok,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [TRACK_W-1:0]      head_pos,
    output logic                    track_zero_n,
    output logic                    fetch_req,
    output logic [SLOT_W-1:0]       fetch_slot,
    output logic [OFF_W-1:0]        fetch_offset,
    output logic                    seek_needed,
    output logic                    stream_on,
    output logic                    busy_res,
    output logic                    failed
);

    ftbr_cmd_t  cmd;
    ftbr_stat_t stat;

    assign cfg_ready = 1'b1;

    ftbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .fetch_ok  (fetch_ok),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ftbr_datapath #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .step_dir     (step_dir),
        .side_pin     (side_pin),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .head_pos     (head_pos),
        .track_zero_n (track_zero_n),
        .fetch_req    (fetch_req),
        .fetch_slot   (fetch_slot),
        .fetch_offset (fetch_offset),
        .seek_needed  (seek_needed),
        .stream_on    (stream_on),
        .busy_res     (busy_res),
        .failed       (failed)
    );

endmodule

`default_nettype wire

[tb/sv/floppy_track_buffer_refill_checker.sv]
`timescale 1ns / 100ps

module floppy_track_buffer_refill_checker
    import ftbr_pkg::*;
#(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [TRACK_W-1:0] cfg_data,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [2:0]         mode,
    input  wire logic               step_dir,
    input  wire logic               side_pin,
    input  wire logic               fetch_ok,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [TRACK_W-1:0] head_pos,
    input  wire logic               track_zero_n,
    input  wire logic               fetch_req,
    input  wire logic [SLOT_W-1:0]  fetch_slot,
    input  wire logic [OFF_W-1:0]   fetch_offset,
    input  wire logic               seek_needed,
    input  wire logic               stream_on,
    input  wire logic               busy_res,
    input  wire logic               failed,
    output int                      fail_count,
    output int                      outstanding
);

    typedef struct packed {
        logic [TRACK_W-1:0] head_pos;
        logic               track_zero_n;
        logic               fetch_req;
        logic [SLOT_W-1:0]  fetch_slot;
        logic [OFF_W-1:0]   fetch_offset;
        logic               seek_needed;
        logic               stream_on;
        logic               busy_res;
        logic               failed;
    } drive_status_t;

    logic [TRACK_W-1:0] head_limit;
    logic [TRACK_W-1:0] head;
    logic [TAG_W-1:0]   slot_tags [NUM_BLOCKS];
    int                 scan_ptr;
    logic [OFF_W-1:0]   next_off;
    logic               streaming;
    logic               fetch_busy;
    logic [PTAG_W-1:0]  fetch_tag;
    logic               running;
    logic               fault;

    drive_status_t due_status [$];
    drive_status_t seen_status;
    drive_status_t oldest_status;
    drive_status_t new_status;

    task automatic clear_drive();
        int i;
        begin
            head = '0;
            for (i = 0; i < NUM_BLOCKS; i++)
                slot_tags[i] = TAG_RESET;
            scan_ptr   = 0;
            next_off   = '0;
            streaming  = 1'b0;
            fetch_busy = 1'b0;
            fetch_tag  = '0;
            running    = 1'b0;
            fault      = 1'b0;
        end
    endtask

    task automatic apply_drive_cmd(input logic [2:0] m, input logic dir, input logic sel,
                                   input logic ok, output drive_status_t r);
        int               slot;
        int               i;
        logic             side;
        logic [TAG_W-1:0] want;
        logic [31:0]      off_full;
        logic             all_match;
        begin
            r = '0;
            case (m)
                MODE_START:
                begin
                    clear_drive();
                    running = 1'b1;
                end
                MODE_STEP:
                begin
                    if (!dir)
                    begin
                        if (head < head_limit)
                            head = head + 1'b1;
                    end
                    else if (head != 0)
                        head = head - 1'b1;
                end
                MODE_SCAN:
                begin
                    if (running)
                    begin
                        if (fetch_busy)
                            r.busy_res = 1'b1;
                        else
                        begin
                            slot = scan_ptr;
                            side = !sel;
                            want = {head, 1'b0, side};
                            if (slot >= NUM_BLOCKS)
                                slot = 0;
                            if (slot_tags[slot] != want)
                            begin
                                slot_tags[slot] = want;
                                off_full = ((32'(head) * 2 + 32'(side)) * NUM_BLOCKS + slot)
                                           * BLOCK_BYTES;
                                r.seek_needed  = off_full[OFF_W-1:0] != next_off;
                                r.fetch_req    = 1'b1;
                                r.fetch_slot   = SLOT_W'(slot);
                                r.fetch_offset = off_full[OFF_W-1:0];
                                off_full       = off_full + BLOCK_BYTES;
                                next_off       = off_full[OFF_W-1:0];
                                streaming      = 1'b0;
                                fetch_busy     = 1'b1;
                                fetch_tag      = {head, side};
                            end
                            slot++;
                            if (slot >= NUM_BLOCKS)
                                slot = 0;
                            scan_ptr = slot;
                        end
                    end
                end
                MODE_FETCH:
                begin
                    if (running && fetch_busy)
                    begin
                        fetch_busy = 1'b0;
                        if (!ok)
                        begin
                            fault     = 1'b1;
                            running   = 1'b0;
                            streaming = 1'b0;
                        end
                        else
                        begin
                            want      = {fetch_tag[PTAG_W-1:1], 1'b0, fetch_tag[0]};
                            all_match = 1'b1;
                            for (i = 0; i < NUM_BLOCKS; i++)
                                if (slot_tags[i] != want)
                                    all_match = 1'b0;
                            streaming = all_match;
                        end
                    end
                end
                MODE_STOP:
                begin
                    running    = 1'b0;
                    streaming  = 1'b0;
                    fetch_busy = 1'b0;
                end
                default:
                begin
                end
            endcase
            r.head_pos     = head;
            r.track_zero_n = head != 0;
            r.stream_on    = streaming;
            r.failed       = fault;
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_drive();
            head_limit = MAX_TRACK_RESET;
            due_status.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                head_limit = cfg_data;
            if (out_valid && out_ready)
            begin
                seen_status = '{head_pos, track_zero_n, fetch_req, fetch_slot, fetch_offset,
                                seek_needed, stream_on, busy_res, failed};
                if (due_status.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    fail_count++;
                end
                else
                begin
                    oldest_status = due_status.pop_front();
                    check_field("head_pos", 32'(oldest_status.head_pos),
                                32'(seen_status.head_pos));
                    check_field("track_zero_n", 32'(oldest_status.track_zero_n),
                                32'(seen_status.track_zero_n));
                    check_field("fetch_req", 32'(oldest_status.fetch_req),
                                32'(seen_status.fetch_req));
                    check_field("fetch_slot", 32'(oldest_status.fetch_slot),
                                32'(seen_status.fetch_slot));
                    check_field("fetch_offset", 32'(oldest_status.fetch_offset),
                                32'(seen_status.fetch_offset));
                    check_field("seek_needed", 32'(oldest_status.seek_needed),
                                32'(seen_status.seek_needed));
                    check_field("stream_on", 32'(oldest_status.stream_on),
                                32'(seen_status.stream_on));
                    check_field("busy_res", 32'(oldest_status.busy_res),
                                32'(seen_status.busy_res));
                    check_field("failed", 32'(oldest_status.failed),
                                32'(seen_status.failed));
                end
            end
            if (in_valid && in_ready)
            begin
                apply_drive_cmd(mode, step_dir, side_pin, fetch_ok, new_status);
                due_status.push_back(new_status);
            end
            outstanding <= due_status.size();
        end
    end

endmodule

[tb/sv/floppy_track_buffer_refill_tb.sv]
`timescale 1ns / 100ps

module floppy_track_buffer_refill_tb;
    import ftbr_pkg::*;

    localparam int NUM_BLOCKS  = NUM_BLOCKS_DEF;
    localparam int BLOCK_BYTES = BLOCK_BYTES_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SEGMENTS    = 8;
    localparam int SEG_ITEMS   = 200;

    localparam logic [2:0] MODE_SPARE5 = 3'd5;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [TRACK_W-1:0] cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         mode;
    logic               step_dir;
    logic               side_pin;
    logic               fetch_ok;
    logic               out_valid;
    logic               out_ready;
    logic [TRACK_W-1:0] head_pos;
    logic               track_zero_n;
    logic               fetch_req;
    logic [SLOT_W-1:0]  fetch_slot;
    logic [OFF_W-1:0]   fetch_offset;
    logic               seek_needed;
    logic               stream_on;
    logic               busy_res;
    logic               failed;

    int fail_count;
    int outstanding;
    int send_idle;
    int recv_idle;
    int cycles;

    logic [TRACK_W-1:0] track_limits [SEGMENTS] = '{8'd255, 8'd0, 8'd79, 8'd1,
                                                    8'd254, 8'd128, 8'd255, 8'd40};

    floppy_track_buffer_refill #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .step_dir     (step_dir),
        .side_pin     (side_pin),
        .fetch_ok     (fetch_ok),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .head_pos     (head_pos),
        .track_zero_n (track_zero_n),
        .fetch_req    (fetch_req),
        .fetch_slot   (fetch_slot),
        .fetch_offset (fetch_offset),
        .seek_needed  (seek_needed),
        .stream_on    (stream_on),
        .busy_res     (busy_res),
        .failed       (failed)
    );

    floppy_track_buffer_refill_checker #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) drive_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .step_dir     (step_dir),
        .side_pin     (side_pin),
        .fetch_ok     (fetch_ok),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .head_pos     (head_pos),
        .track_zero_n (track_zero_n),
        .fetch_req    (fetch_req),
        .fetch_slot   (fetch_slot),
        .fetch_offset (fetch_offset),
        .seek_needed  (seek_needed),
        .stream_on    (stream_on),
        .busy_res     (busy_res),
        .failed       (failed),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        mode      = MODE_START;
        step_dir  = 1'b0;
        side_pin  = 1'b0;
        fetch_ok  = 1'b0;
        out_ready = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        cycles    = 0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic send_cmd(input logic [2:0] m, input logic dir, input logic sel,
                            input logic ok);
        begin
            if ($urandom_range(0, 99) < send_idle)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while ($urandom_range(0, 99) < send_idle)
                    @(posedge clk);
            end
            in_valid <= 1'b1;
            mode     <= m;
            step_dir <= dir;
            side_pin <= sel;
            fetch_ok <= ok;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
        end
    endtask

    // drop valid and hold until every result transfer has come back
    task automatic drain();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (outstanding != 0)
                @(posedge clk);
        end
    endtask

    task automatic write_head_limit(input logic [TRACK_W-1:0] value);
        begin
            cfg_valid <= 1'b1;
            cfg_data  <= value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic run_drive_traffic(input int quota, input int up_pct);
        int       sent;
        int       pick;
        int       n;
        logic     sel;
        logic [2:0] m;
        begin
            sent = 0;
            while (sent < quota)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                begin
                    send_cmd(MODE_START, coin(), coin(), coin());
                    sent++;
                end
                else if (pick < 28)
                begin
                    n = $urandom_range(1, 12);
                    repeat (n)
                        send_cmd(MODE_STEP, $urandom_range(0, 99) >= up_pct,
                                 coin(), coin());
                    sent += n;
                end
                else if (pick < 86)
                begin
                    // refill sweep: scan then fetch done, mostly for one side
                    n   = $urandom_range(1, 30);
                    sel = coin();
                    repeat (n)
                    begin
                        if ($urandom_range(0, 99) < 4)
                            sel = ~sel;
                        if ($urandom_range(0, 99) < 3)
                        begin
                            send_cmd(MODE_STEP, $urandom_range(0, 99) >= up_pct,
                                     coin(), coin());
                            sent++;
                        end
                        send_cmd(MODE_SCAN, coin(), sel, coin());
                        sent++;
                        if ($urandom_range(0, 99) < 92)
                        begin
                            send_cmd(MODE_FETCH, coin(), coin(),
                                     $urandom_range(0, 99) >= 2);
                            sent++;
                        end
                    end
                end
                else if (pick < 91)
                begin
                    send_cmd(MODE_STOP, coin(), coin(), coin());
                    sent++;
                end
                else
                begin
                    m = 3'($urandom_range(0, 7));
                    send_cmd(m, coin(), coin(), coin());
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        int seg;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 37;
        recv_idle = 57;
        write_head_limit(8'd3);

        send_cmd(MODE_SCAN, 1'b0, 1'b1, 1'b0);
        send_cmd(MODE_FETCH, 1'b0, 1'b0, 1'b1);
        send_cmd(MODE_STEP, 1'b1, 1'b0, 1'b0);
        send_cmd(MODE_START, 1'b0, 1'b0, 1'b0);
        repeat (4)
            send_cmd(MODE_STEP, 1'b0, 1'b0, 1'b0);
        send_cmd(MODE_STEP, 1'b1, 1'b0, 1'b0);
        send_cmd(MODE_SCAN, 1'b0, 1'b1, 1'b0);
        send_cmd(MODE_SCAN, 1'b0, 1'b1, 1'b0);
        send_cmd(MODE_FETCH, 1'b0, 1'b0, 1'b1);
        send_cmd(MODE_SCAN, 1'b0, 1'b1, 1'b0);
        send_cmd(MODE_FETCH, 1'b0, 1'b0, 1'b0);
        send_cmd(MODE_SCAN, 1'b0, 1'b1, 1'b0);
        send_cmd(MODE_STOP, 1'b0, 1'b0, 1'b0);
        send_cmd(MODE_SPARE5, 1'b1, 1'b1, 1'b1);
        send_cmd(MODE_SPARE6, 1'b1, 1'b1, 1'b1);
        send_cmd(MODE_SPARE7, 1'b1, 1'b1, 1'b1);
        send_cmd(MODE_START, 1'b1, 1'b1, 1'b1);
        send_cmd(MODE_SCAN, 1'b1, 1'b0, 1'b1);
        send_cmd(MODE_STOP, 1'b1, 1'b1, 1'b1);
        send_cmd(MODE_FETCH, 1'b1, 1'b1, 1'b1);

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg < 3)
            begin
                send_idle = 37;
                recv_idle = 57;
            end
            else if (seg < 6)
            begin
                send_idle = 57;
                recv_idle = 37;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            drain();
            write_head_limit(track_limits[seg]);
            run_drive_traffic(SEG_ITEMS, (seg % 2 == 0) ? 80 : 40);
        end

        drain();
        repeat (NUM_BLOCKS + 8) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
